### hw/rtl/phase_angle_triac_dimmer_assert.svh
// Assertion macros shared by the phase-angle dimmer RTL.
// Define NO_ASSERTIONS to compile every use of these macros to nothing.
`ifndef PHASE_ANGLE_TRIAC_DIMMER_ASSERT_SVH
`define PHASE_ANGLE_TRIAC_DIMMER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define PATD_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication, checked out of reset
`define PATD_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define PATD_ASSERT_IMP(name, clk, rst, ante, cons)
`define PATD_ASSERT_NXT(name, clk, rst, ante, cons)

`endif

`endif

### hw/rtl/patd_pkg.sv
// Types and constants of the phase-angle triac dimmer.
// No dependencies; imported by every module of the block.
package patd_pkg;

   localparam int LevelWidth = 8;
   localparam int KindWidth  = 3;
   localparam int CsrIdxWidth = 2;

   localparam logic [KindWidth-1:0] KIND_TICK       = 3'd0;
   localparam logic [KindWidth-1:0] KIND_ZERO_CROSS = 3'd1;
   localparam logic [KindWidth-1:0] KIND_SET        = 3'd2;
   localparam logic [KindWidth-1:0] KIND_DARKER     = 3'd3;
   localparam logic [KindWidth-1:0] KIND_BRIGHTER   = 3'd4;

   localparam logic [CsrIdxWidth-1:0] CSR_MANUAL_STEP = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_SENSOR_STEP = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_PERIOD_END  = 2'd2;

   localparam logic [LevelWidth-1:0] LEVEL_FULL_ON  = 8'h00;
   localparam logic [LevelWidth-1:0] LEVEL_FULL_OFF = 8'hFF;

   localparam logic [LevelWidth-1:0] MANUAL_STEP_RST = 8'd5;
   localparam logic [LevelWidth-1:0] SENSOR_STEP_RST = 8'd20;
   localparam logic [LevelWidth-1:0] PERIOD_END_RST  = 8'd255;

   typedef struct packed {
      logic [KindWidth-1:0]  kind;
      logic [LevelWidth-1:0] new_level;
      logic                  from_sensor;
   } req_item_type;

   typedef struct packed {
      logic                  gate_on;
      logic [LevelWidth-1:0] level_now;
      logic                  phase_running;
   } rsp_item_type;

   typedef struct packed {
      logic [LevelWidth-1:0] manual_step;
      logic [LevelWidth-1:0] sensor_step;
      logic [LevelWidth-1:0] period_end;
   } csr_cfg_type;

endpackage

### hw/rtl/patd_csr.sv
// Configuration registers: manual step, sensor step and period end.
// Depends on patd_pkg.
module patd_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [patd_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [patd_pkg::LevelWidth-1:0]   csr_wdata,
   output patd_pkg::csr_cfg_type             cfg
);
   import patd_pkg::*;

   csr_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MANUAL_STEP: cfg_in.manual_step = csr_wdata;
            CSR_SENSOR_STEP: cfg_in.sensor_step = csr_wdata;
            CSR_PERIOD_END:  cfg_in.period_end  = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.manual_step <= MANUAL_STEP_RST;
         cfg_ff.sensor_step <= SENSOR_STEP_RST;
         cfg_ff.period_end  <= PERIOD_END_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hw/rtl/patd_core.sv
// Dimmer state (level, phase counter, gate) and its per-transaction update.
// Depends on patd_pkg and the assertion macro header.
`include "phase_angle_triac_dimmer_assert.svh"

module patd_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  patd_pkg::req_item_type item,
   input  patd_pkg::csr_cfg_type  cfg,
   output patd_pkg::rsp_item_type result
);
   import patd_pkg::*;

   logic [LevelWidth-1:0] level_ff, level_in;
   logic [LevelWidth-1:0] tick_ff, tick_in;
   logic                  counting_ff, counting_in;
   logic                  gate_ff, gate_in;

   logic [LevelWidth-1:0] step;
   logic [LevelWidth:0]   darker_sum;
   logic [LevelWidth:0]   brighter_diff;
   logic [LevelWidth-1:0] tick_inc;
   logic [LevelWidth-1:0] new_lvl;
   logic                  lvl_write;
   logic                  lvl_extreme;
   logic                  level_mid;

   assign step          = item.from_sensor ? cfg.sensor_step : cfg.manual_step;
   assign darker_sum    = {1'b0, level_ff} + {1'b0, step};
   assign brighter_diff = {1'b0, level_ff} - {1'b0, step};
   assign tick_inc      = tick_ff + 8'd1;
   assign level_mid     = (level_ff != LEVEL_FULL_ON) && (level_ff != LEVEL_FULL_OFF);

   // level selection for set / step transactions; saturates at both ends
   always_comb begin
      lvl_write = 1'b0;
      new_lvl   = level_ff;
      unique case (item.kind)
         KIND_SET: begin
            lvl_write = 1'b1;
            new_lvl   = item.new_level;
         end
         KIND_DARKER: begin
            lvl_write = 1'b1;
            new_lvl   = darker_sum[LevelWidth] ? LEVEL_FULL_OFF : darker_sum[LevelWidth-1:0];
         end
         KIND_BRIGHTER: begin
            lvl_write = 1'b1;
            new_lvl   = brighter_diff[LevelWidth] ? LEVEL_FULL_ON
                                                  : brighter_diff[LevelWidth-1:0];
         end
         default: begin
            lvl_write = 1'b0;
            new_lvl   = level_ff;
         end
      endcase
   end

   assign lvl_extreme = (new_lvl == LEVEL_FULL_ON) || (new_lvl == LEVEL_FULL_OFF);

   always_comb begin
      level_in    = level_ff;
      tick_in     = tick_ff;
      counting_in = counting_ff;
      gate_in     = gate_ff;
      if (step_en) begin
         if (lvl_write) begin
            level_in = new_lvl;
            // full on / full off stop the phase timer and force the gate
            if (lvl_extreme) begin
               counting_in = 1'b0;
               tick_in     = '0;
               gate_in     = (new_lvl == LEVEL_FULL_ON);
            end
         end else if (item.kind == KIND_TICK) begin
            if (counting_ff) begin
               // period end wins over the level compare
               if (tick_inc == cfg.period_end) begin
                  gate_in     = 1'b0;
                  counting_in = 1'b0;
                  tick_in     = '0;
               end else begin
                  tick_in = tick_inc;
                  if (tick_inc == level_ff) begin
                     gate_in = 1'b1;
                  end
               end
            end
         end else if (item.kind == KIND_ZERO_CROSS) begin
            if (level_mid) begin
               counting_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff    <= LEVEL_FULL_ON;
         tick_ff     <= '0;
         counting_ff <= 1'b0;
         gate_ff     <= 1'b1;
      end else begin
         level_ff    <= level_in;
         tick_ff     <= tick_in;
         counting_ff <= counting_in;
         gate_ff     <= gate_in;
      end
   end

   // result shows the state after the transaction
   assign result.gate_on       = gate_in;
   assign result.level_now     = level_in;
   assign result.phase_running = counting_in;

   `PATD_ASSERT_IMP(a_idle_count_clear, clock, reset, !counting_ff, tick_ff == '0)
   `PATD_ASSERT_IMP(a_extreme_no_count, clock, reset, !level_mid, !counting_ff)
   `PATD_ASSERT_IMP(a_full_on_gate, clock, reset, level_ff == LEVEL_FULL_ON, gate_ff)
   `PATD_ASSERT_IMP(a_full_off_gate, clock, reset, level_ff == LEVEL_FULL_OFF, !gate_ff)

endmodule

### hw/rtl/phase_angle_triac_dimmer.sv
// An accepted transaction lands in the input register, then in the result register
// (which drives rsp_valid) once it is free. Throughput: one transaction per cycle
// unless rsp_stall holds the result register; the state update is one add or subtract
// and a few compares between the two registers. Reset (synchronous, active high):
// level 0, gate on, phase timer stopped and cleared, configuration at its defaults, both
// pipeline registers empty. Depends on patd_pkg, patd_csr, patd_core, assertion macros.
`include "phase_angle_triac_dimmer_assert.svh"

module phase_angle_triac_dimmer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  patd_pkg::req_item_type            req_item,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output patd_pkg::rsp_item_type            rsp_item,
   input  logic                              csr_wr_en,
   input  logic [patd_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [patd_pkg::LevelWidth-1:0]   csr_wdata
);
   import patd_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff, in_item_in;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff, out_item_in;

   csr_cfg_type  cfg;
   rsp_item_type core_result;
   logic         out_free;
   logic         advance;
   logic         req_take;

   patd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   patd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (core_result)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_item_in  = req_item;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_item_in  = core_result;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   `PATD_ASSERT_NXT(a_advance_fills_out, clock, reset, advance, out_valid_ff)
   `PATD_ASSERT_NXT(a_take_fills_in, clock, reset, req_take, in_valid_ff)
   `PATD_ASSERT_IMP(a_stall_only_when_full, clock, reset, req_stall, in_valid_ff && out_valid_ff)

endmodule
